/* sv/swg_pkg.sv */
package swg_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TYPE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH    = 2'd2;

	localparam logic [2:0] WIN_RECT     = 3'd0;
	localparam logic [2:0] WIN_HAMMING  = 3'd1;
	localparam logic [2:0] WIN_HANN     = 3'd2;
	localparam logic [2:0] WIN_GAUSS    = 3'd3;
	localparam logic [2:0] WIN_BLACKMAN = 3'd4;

	localparam logic [2:0]  RST_WINDOW_TYPE   = WIN_HAMMING;
	localparam logic [12:0] RST_WINDOW_LENGTH = 13'd256;
	localparam logic [15:0] RST_HALF_WIDTH    = 16'd32768;

	localparam logic [29:0] ONE28      = 30'h1000_0000;
	localparam logic [30:0] ONE30      = 31'h4000_0000;
	localparam logic [29:0] HAM_BIAS   = 30'd21474836;
	localparam logic [26:0] HAM_GAIN   = 27'd123480310;
	localparam logic [24:0] BLK_COEF   = 25'd21474836;
	localparam logic [29:0] BLK_OFFSET = 30'd42949672;

	localparam int QUEUE_DEPTH = 4;
	localparam int DIV_STEPS   = 16;
	localparam int COS_LAT     = 7;
	localparam int GAUSS_LAT   = 28;

	typedef struct packed {
		logic        oor;
		logic [2:0]  wtype;
		logic [12:0] span;
		logic [28:0] den;
	} swg_item_t;

	typedef struct packed {
		logic       oor;
		logic       pass;
		logic [2:0] wtype;
	} swg_side_t;

	typedef struct packed {
		logic empty;
		logic full;
	} swg_qstat_t;

	// Taylor coefficients pi^2k/(2k)! in Q28.
	function automatic logic [30:0] cos_coef(input int k);
		logic [30:0] c;
		case (k)
			0:       c = 31'd268435456;
			1:       c = 31'd1324675879;
			2:       c = 31'd1089502240;
			3:       c = 31'd358431870;
			4:       c = 31'd63171085;
			5:       c = 31'd6927485;
			default: c = '0;
		endcase
		return c;
	endfunction

	// floor(2^32 / k) for the series divisors.
	function automatic logic [32:0] recip_coef(input int k);
		logic [32:0] m;
		case (k)
			1:       m = 33'd4294967296;
			2:       m = 33'd2147483648;
			3:       m = 33'd1431655765;
			4:       m = 33'd1073741824;
			5:       m = 33'd858993459;
			6:       m = 33'd715827882;
			7:       m = 33'd613566756;
			8:       m = 33'd536870912;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

/* sv/spectral_window_generator_unit.sv */
// Channel  Handshake               Payload
// in       in_valid / in_stall     sample_index
// out      out_valid / out_stall   weight, index_out_of_range
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request is taken per clock and one result leaves per clock when nothing stalls.
// A result is valid once its request has passed the front register and queue, the divider,
// the Gaussian series, and the blend and output registers.
// Reset selects a Hamming window of length 256 and half width 0.5, with the pipeline empty.
// A stalled result freezes the back pipeline; the four-entry queue keeps taking requests.
// in_stall rises only when that queue is full and the front register holds a request.
module spectral_window_generator_unit #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] sample_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] weight,
	output logic        index_out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import swg_pkg::*;

	localparam int TDLY = GAUSS_LAT - COS_LAT;

	logic [2:0]  window_type_q;
	logic [12:0] window_length_q;
	logic [15:0] half_width_q;

	swg_item_t  front_item;
	logic       front_push;
	swg_item_t  head;
	swg_qstat_t qstat;
	logic       adv;
	logic       pop;

	logic        v_d    [0:DIV_STEPS];
	swg_side_t   side_d [0:DIV_STEPS];
	logic [28:0] rem_d  [0:DIV_STEPS-1];
	logic [28:0] den_d  [0:DIV_STEPS-1];
	logic [15:0] q_d    [1:DIV_STEPS];
	logic [27:0] scaled;
	logic [15:0] t_div;

	logic [15:0] t_dl   [1:TDLY];
	logic        v_g    [1:GAUSS_LAT];
	swg_side_t   side_g [1:GAUSS_LAT];
	logic [29:0] cpa;
	logic [29:0] cpb;
	logic [28:0] gw;

	logic        v_m;
	swg_side_t   side_m;
	logic [56:0] ph_full;
	logic [54:0] pb_full;
	logic [28:0] ph_m;
	logic [26:0] pb_m;
	logic [28:0] half_m;
	logic [28:0] gw_m;

	logic [29:0] blk_sum;
	logic [29:0] w_sel;
	logic [29:0] w_clamp;
	logic [30:0] w_rnd;

	logic        out_valid_q;
	logic [15:0] weight_q;
	logic        oor_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_type_q   <= RST_WINDOW_TYPE;
			window_length_q <= RST_WINDOW_LENGTH;
			half_width_q    <= RST_HALF_WIDTH;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW_TYPE:   window_type_q   <= cfg_data[2:0];
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[12:0];
				CFG_HALF_WIDTH:    half_width_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	swg_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.window_length(window_length_q),
		.half_width   (half_width_q),
		.window_type  (window_type_q),
		.qstat        (qstat),
		.item         (front_item),
		.push         (front_push)
	);

	swg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.push_item(front_item),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// The whole back pipeline moves together unless a finished result is held.
	assign adv = !(out_valid_q && out_stall);
	assign pop = adv && !qstat.empty;

	// Cutoff test and start of the restoring division of span*2^31 by den.
	assign scaled = {head.span, 15'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0].oor   <= head.oor;
			side_d[0].pass  <= ({1'b0, scaled} < head.den);
			side_d[0].wtype <= head.wtype;
			rem_d[0]        <= {1'b0, scaled};
			den_d[0]        <= head.den;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [29:0] r2;
		logic [29:0] diff;
		logic        ge;

		assign r2   = {rem_d[j], 1'b0};
		assign diff = r2 - {1'b0, den_d[j]};
		assign ge   = (r2 >= {1'b0, den_d[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[j+1] <= 1'b0;
			end else if (adv) begin
				v_d[j+1] <= v_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_d[j+1] <= side_d[j];
			end
		end

		if (j == 0) begin : g_qfirst
			always_ff @(posedge clk) begin
				if (adv) begin
					q_d[1] <= {15'd0, ge};
				end
			end
		end else begin : g_qrest
			always_ff @(posedge clk) begin
				if (adv) begin
					q_d[j+1] <= {q_d[j][14:0], ge};
				end
			end
		end

		if (j < DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_d[j+1] <= ge ? diff[28:0] : r2[28:0];
					den_d[j+1] <= den_d[j];
				end
			end
		end
	end

	assign t_div = q_d[DIV_STEPS];

	// The cosine lanes are shorter than the Gaussian lane, so their angle
	// is delayed to line both up.
	always_ff @(posedge clk) begin
		if (adv) begin
			t_dl[1]   <= t_div;
			side_g[1] <= side_d[DIV_STEPS];
			for (int s = 2; s <= TDLY; s++) begin
				t_dl[s] <= t_dl[s-1];
			end
			for (int s = 2; s <= GAUSS_LAT; s++) begin
				side_g[s] <= side_g[s-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= GAUSS_LAT; s++) begin
				v_g[s] <= 1'b0;
			end
		end else if (adv) begin
			v_g[1] <= v_d[DIV_STEPS];
			for (int s = 2; s <= GAUSS_LAT; s++) begin
				v_g[s] <= v_g[s-1];
			end
		end
	end

	swg_cos u_cos_a (
		.clk  (clk),
		.en   (adv),
		.phase({1'b0, t_dl[TDLY]}),
		.cp1  (cpa)
	);

	swg_cos u_cos_b (
		.clk  (clk),
		.en   (adv),
		.phase({t_dl[TDLY], 1'b0}),
		.cp1  (cpb)
	);

	swg_gauss u_gauss (
		.clk(clk),
		.en (adv),
		.t  (t_div),
		.w28(gw)
	);

	// Constant products for the Hamming and Blackman blends.
	assign ph_full = 57'(cpa) * 57'(HAM_GAIN);
	assign pb_full = 55'(cpb) * 55'(BLK_COEF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else if (adv) begin
			v_m <= v_g[GAUSS_LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_m <= side_g[GAUSS_LAT];
			ph_m   <= ph_full[56:28];
			pb_m   <= pb_full[54:28];
			half_m <= cpa[29:1];
			gw_m   <= gw;
		end
	end

	always_comb begin
		blk_sum = 30'(half_m) + 30'(pb_m);
		unique case (side_m.wtype)
			WIN_RECT:     w_sel = ONE28;
			WIN_HAMMING:  w_sel = HAM_BIAS + 30'(ph_m);
			WIN_HANN:     w_sel = 30'(half_m);
			WIN_GAUSS:    w_sel = 30'(gw_m);
			WIN_BLACKMAN: w_sel = (blk_sum > BLK_OFFSET) ? (blk_sum - BLK_OFFSET) : '0;
			default:      w_sel = '0;
		endcase
		if (!side_m.pass) begin
			w_sel = '0;
		end
		w_clamp = (w_sel > ONE28) ? ONE28 : w_sel;
		w_rnd   = 31'(w_clamp) + 31'd4096;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_q    <= side_m.oor;
			weight_q <= side_m.oor ? 16'd0 : w_rnd[28:13];
		end
	end

	assign out_valid          = out_valid_q;
	assign weight             = weight_q;
	assign index_out_of_range = oor_q;

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && index_out_of_range) |-> (weight == 16'd0))
		else $error("out-of-range index produced a nonzero weight");

	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (weight <= 16'd32768))
		else $error("weight above unity");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.empty && qstat.full))
		else $error("request queue reports empty and full at once");
`endif

endmodule

/* sv/swg_front.sv */
module swg_front #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        sample_index,
	input  logic [12:0]        window_length,
	input  logic [15:0]        half_width,
	input  logic [2:0]         window_type,
	input  swg_pkg::swg_qstat_t qstat,
	output swg_pkg::swg_item_t  item,
	output logic               push
);
	import swg_pkg::*;

	localparam logic [16:0] LEN_CAP = 17'(MAX_LENGTH);

	logic        valid_s1;
	swg_item_t   item_s1;
	logic        accept;
	logic [16:0] len_ext;
	logic [12:0] n;
	logic [12:0] twice_i;
	swg_item_t   item_new;

	assign len_ext = {4'd0, window_length};
	assign n       = (len_ext > LEN_CAP) ? LEN_CAP[12:0] : window_length;
	assign twice_i = {sample_index, 1'b0};

	always_comb begin
		item_new.oor   = ({1'b0, sample_index} >= n);
		item_new.wtype = window_type;
		item_new.span  = (twice_i >= n) ? (twice_i - n) : (n - twice_i);
		item_new.den   = 29'(half_width) * 29'(n);
	end

	assign in_stall = valid_s1 && qstat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !qstat.full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_new;
		end
	end

endmodule

/* sv/swg_queue.sv */
module swg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  swg_pkg::swg_item_t  push_item,
	input  logic                pop,
	output swg_pkg::swg_item_t  head,
	output swg_pkg::swg_qstat_t qstat
);
	import swg_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	swg_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/swg_cos.sv */
module swg_cos (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] phase,
	output logic [29:0] cp1
);
	import swg_pkg::*;

	logic [16:0] pf;
	logic [15:0] y;
	logic        neg;
	logic [31:0] yy;

	logic [28:0] z_s   [1:5];
	logic        neg_s [1:6];
	logic [30:0] acc_s [2:6];
	logic [29:0] cp1_s7;

	// Fold the angle into the first quarter turn; the second quarter is
	// reflected and its sign carried along.
	always_comb begin
		pf = (phase > 17'd65536) ? (17'd0 - phase) : phase;
		if (pf <= 17'd32768) begin
			y   = pf[15:0];
			neg = 1'b0;
		end else begin
			y   = 16'(17'd65536 - pf);
			neg = 1'b1;
		end
		yy = 32'(y) * 32'(y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[1]   <= yy[30:2];
			neg_s[1] <= neg;
		end
	end

	for (genvar j = 1; j <= 5; j++) begin : g_horner
		localparam int K = 5 - j;
		logic [30:0] a;
		logic [59:0] prod;
		logic [30:0] sh;
		logic [30:0] c;
		logic [30:0] nxt;

		if (j == 1) begin : g_first
			assign a = cos_coef(5);
		end else begin : g_rest
			assign a = acc_s[j];
		end

		assign prod = 60'(a) * 60'(z_s[j]);
		assign sh   = {1'b0, prod[59:30]};
		assign c    = cos_coef(K);
		assign nxt  = (c > sh) ? (c - sh) : '0;

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j+1] <= nxt;
				neg_s[j+1] <= neg_s[j];
			end
		end

		if (j < 5) begin : g_zpass
			always_ff @(posedge clk) begin
				if (en) begin
					z_s[j+1] <= z_s[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[6]) begin
				cp1_s7 <= (ONE28 > acc_s[6][29:0]) ? (ONE28 - acc_s[6][29:0]) : '0;
			end else begin
				cp1_s7 <= ONE28 + acc_s[6][29:0];
			end
		end
	end

	assign cp1 = cp1_s7;

endmodule

/* sv/swg_gauss.sv */
module swg_gauss (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] t,
	output logic [28:0] w28
);
	import swg_pkg::*;

	logic [31:0] tt;
	logic [35:0] g9;
	logic [29:0] g_s1;

	logic [29:0] v_a   [0:7];
	logic [29:0] g_a   [0:7];
	logic [29:0] v_b   [0:7];
	logic [29:0] qe_b  [0:7];
	logic [29:0] g_b   [0:6];
	logic [30:0] acc_c [0:7];
	logic [29:0] g_c   [0:6];
	logic [30:0] sq_s  [1:3];

	assign tt = 32'(t) * 32'(t);
	assign g9 = {1'b0, tt, 3'd0} + {4'd0, tt};

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= g9[35:6];
		end
	end

	// Each series step takes three stages: the product with g, the
	// reciprocal multiply for the divisor, then the correction and subtract.
	for (genvar j = 0; j < 8; j++) begin : g_series
		localparam int K = 8 - j;
		logic [29:0] g_in;
		logic [30:0] acc_in;
		logic [60:0] prod;
		logic [62:0] pm;
		logic [32:0] qk;
		logic [29:0] r;
		logic [29:0] q;

		if (j == 0) begin : g_first
			assign g_in   = g_s1;
			assign acc_in = ONE30;
		end else begin : g_rest
			assign g_in   = g_c[j-1];
			assign acc_in = acc_c[j-1];
		end

		assign prod = 61'(g_in) * 61'(acc_in);
		assign pm   = 63'(v_a[j]) * 63'(recip_coef(K));
		assign qk   = 33'(qe_b[j]) * 33'(K);
		assign r    = v_b[j] - qk[29:0];
		assign q    = (r >= 30'(K)) ? (qe_b[j] + 30'd1) : qe_b[j];

		always_ff @(posedge clk) begin
			if (en) begin
				v_a[j]   <= prod[59:30];
				g_a[j]   <= g_in;
				v_b[j]   <= v_a[j];
				qe_b[j]  <= pm[61:32];
				acc_c[j] <= (ONE30 > {1'b0, q}) ? (ONE30 - {1'b0, q}) : '0;
			end
		end

		if (j < 7) begin : g_gpass
			always_ff @(posedge clk) begin
				if (en) begin
					g_b[j] <= g_a[j];
					g_c[j] <= g_b[j];
				end
			end
		end
	end

	for (genvar s = 1; s <= 3; s++) begin : g_square
		logic [30:0] base;
		logic [61:0] sq;

		if (s == 1) begin : g_first
			assign base = acc_c[7];
		end else begin : g_rest
			assign base = sq_s[s-1];
		end

		assign sq = 62'(base) * 62'(base);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[s] <= sq[60:30];
			end
		end
	end

	assign w28 = sq_s[3][30:2];

endmodule

/* tb/sv/spectral_window_generator_unit_test.sv */
`timescale 1ns / 1ps

module spectral_window_generator_unit_test;
	import swg_pkg::*;

	localparam int MAX_LENGTH = 4096;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [2:0] WIN_UNKNOWN = 3'd5;
	localparam logic [2:0] WIN_RESERVED = 3'd7;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [15:0] weight;
		logic        oor;
	} weight_t;

	typedef struct {
		logic [2:0]  wtype;
		logic [15:0] len;
		logic [15:0] hw;
		logic [11:0] idx;
		bit          known;
		logic [15:0] weight;
		logic        oor;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [11:0] sample_index = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [15:0] weight;
	logic index_out_of_range;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic [2:0]  cur_type = RST_WINDOW_TYPE;
	logic [12:0] cur_len = RST_WINDOW_LENGTH;
	logic [15:0] cur_hw = RST_HALF_WIDTH;

	weight_t pending_weights[$];
	int errors = 0;
	int requests_sent = 0;
	int burst_left = 0;
	bit gaps_on = 1;

	spectral_window_generator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample_index(sample_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.weight(weight), .index_out_of_range(index_out_of_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] sub_floor0(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic logic [63:0] taylor_cos(input logic [63:0] y);
		logic [63:0] z, acc;
		z = (y * y) >> 2;
		acc = cos_coef(5);
		for (int k = 4; k >= 0; k--)
			acc = sub_floor0(cos_coef(k), (acc * z) >> 30);
		return acc;
	endfunction

	// Returns cos(pi p) + 1 in Q28 with p in half turns, Q16, wrapped at two.
	function automatic logic [63:0] cos_biased(input logic [63:0] p);
		p = p & 64'h1FFFF;
		if (p > 65536) p = 131072 - p;
		if (p <= 32768) return 64'd268435456 + taylor_cos(p);
		return sub_floor0(64'd268435456, taylor_cos(65536 - p));
	endfunction

	function automatic logic [63:0] gauss_q28(input logic [63:0] t);
		logic [63:0] g, acc;
		g = (9 * t * t) >> 6;
		acc = 64'd1073741824;
		for (int k = 8; k >= 1; k--)
			acc = sub_floor0(64'd1073741824, ((g * acc) >> 30) / k);
		for (int s = 0; s < 3; s++)
			acc = (acc * acc) >> 30;
		return acc >> 2;
	endfunction

	function automatic weight_t window_weight(input logic [11:0] idx);
		weight_t r;
		logic [63:0] n, i, d, den, t, w28;
		n = cur_len;
		if (n > MAX_LENGTH) n = MAX_LENGTH;
		i = idx;
		w28 = 0;
		if (i >= n) begin
			r.weight = 0;
			r.oor = 1;
			return r;
		end
		d = (2 * i >= n) ? 2 * i - n : n - 2 * i;
		den = cur_hw * n;
		if (d * 32768 < den) begin
			t = ((d << 31) / den) & 64'hFFFF;
			case (cur_type)
				WIN_RECT:     w28 = 64'd268435456;
				WIN_HAMMING:  w28 = 64'd21474836 + ((64'd123480310 * cos_biased(t)) >> 28);
				WIN_HANN:     w28 = cos_biased(t) >> 1;
				WIN_GAUSS:    w28 = gauss_q28(t);
				WIN_BLACKMAN: w28 = sub_floor0((cos_biased(t) >> 1)
					+ ((64'd21474836 * cos_biased(2 * t)) >> 28), 64'd42949672);
				default:      w28 = 0;
			endcase
		end
		if (w28 > 64'd268435456) w28 = 64'd268435456;
		r.weight = 16'((w28 + 4096) >> 13);
		r.oor = 0;
		return r;
	endfunction

	task automatic send_request(input logic [11:0] idx, input bit known, input weight_t typed);
		int gap;
		weight_t pred;
		if (burst_left == 0) begin
			if (gaps_on) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				in_valid = 0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		in_valid = 1;
		sample_index = idx;
		do @(posedge clk); while (in_stall);
		pred = window_weight(idx);
		// The typed value is cross-checked against the predictor as well.
		if (known && typed != pred) begin
			$display("%0t predictor disagrees at index %0d: expected %0d/%0b actual %0d/%0b",
				$time, idx, typed.weight, typed.oor, pred.weight, pred.oor);
			errors++;
		end
		pending_weights.push_back(known ? typed : pred);
		requests_sent++;
		burst_left--;
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid = 0;
		while (pending_weights.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] regno, input logic [15:0] value);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = regno;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (regno)
			CFG_WINDOW_TYPE:   cur_type = value[2:0];
			CFG_WINDOW_LENGTH: cur_len = value[12:0];
			CFG_HALF_WIDTH:    cur_hw = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_window(input logic [2:0] wt, input logic [15:0] len, input logic [15:0] hw);
		drain();
		write_reg(CFG_WINDOW_TYPE, {13'd0, wt});
		write_reg(CFG_WINDOW_LENGTH, len);
		write_reg(CFG_HALF_WIDTH, hw);
	endtask

	// Receiver: the stall pattern's period and duty are redrawn at random, with one long hold-off.
	always @(negedge clk) begin
		static int cyc = 0;
		static int period = 1, duty = 0, hold = 0;
		static bit held = 0;
		if (!held && requests_sent >= 400) begin
			held = 1;
			hold = 300;
		end
		if (cyc % 64 == 0) begin
			period = $urandom_range(1, 9);
			duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, period);
		end
		if (hold > 0) begin
			out_stall = 1;
			hold--;
		end else
			out_stall = (cyc % period) < duty;
		cyc++;
	end

	always @(posedge clk) begin
		weight_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_weights.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0d/%0b",
					$time, weight, index_out_of_range);
				errors++;
			end else begin
				exp_w = pending_weights.pop_front();
				if (weight !== exp_w.weight) begin
					$display("%0t weight mismatch: expected %0d actual %0d",
						$time, exp_w.weight, weight);
					errors++;
				end
				if (index_out_of_range !== exp_w.oor) begin
					$display("%0t index_out_of_range mismatch: expected %0b actual %0b",
						$time, exp_w.oor, index_out_of_range);
					errors++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	row_t rows[$];

	initial begin
		weight_t typed;
		logic [2:0] wt;
		logic [15:0] len, hw;
		int neff, count;
		rows = '{
			'{WIN_HAMMING, 16'd256, 16'd32768, 12'd128, 1, 16'd32768, 1'b0},
			'{WIN_HAMMING, 16'd256, 16'd32768, 12'd0, 1, 16'd0, 1'b0},
			'{WIN_HAMMING, 16'd256, 16'd32768, 12'd256, 1, 16'd0, 1'b1},
			'{WIN_HAMMING, 16'd256, 16'd32768, 12'd4095, 1, 16'd0, 1'b1},
			'{WIN_HAMMING, 16'd256, 16'd32768, 12'd100, 0, 16'd0, 1'b0},
			'{WIN_RECT, 16'd16, 16'd65535, 12'd8, 1, 16'd32768, 1'b0},
			'{WIN_RECT, 16'd16, 16'd65535, 12'd0, 0, 16'd0, 1'b0},
			'{WIN_HANN, 16'd64, 16'd65535, 12'd32, 1, 16'd32768, 1'b0},
			'{WIN_HANN, 16'd64, 16'd65535, 12'd1, 0, 16'd0, 1'b0},
			'{WIN_GAUSS, 16'd64, 16'd65535, 12'd32, 1, 16'd32768, 1'b0},
			'{WIN_GAUSS, 16'd64, 16'd65535, 12'd5, 0, 16'd0, 1'b0},
			'{WIN_BLACKMAN, 16'd64, 16'd65535, 12'd32, 1, 16'd32768, 1'b0},
			'{WIN_BLACKMAN, 16'd64, 16'd65535, 12'd1, 0, 16'd0, 1'b0},
			'{WIN_BLACKMAN, 16'd64, 16'd65535, 12'd63, 0, 16'd0, 1'b0},
			'{WIN_UNKNOWN, 16'd64, 16'd65535, 12'd32, 1, 16'd0, 1'b0},
			'{WIN_RESERVED, 16'd64, 16'd65535, 12'd70, 1, 16'd0, 1'b1},
			'{WIN_HANN, 16'd0, 16'd32768, 12'd0, 1, 16'd0, 1'b1},
			'{WIN_HANN, 16'd2, 16'd1, 12'd1, 1, 16'd32768, 1'b0},
			'{WIN_HANN, 16'd2, 16'd0, 12'd1, 1, 16'd0, 1'b0},
			'{WIN_HAMMING, 16'd8191, 16'd65535, 12'd4095, 0, 16'd0, 1'b0},
			'{WIN_HAMMING, 16'hFFFF, 16'd65535, 12'd2048, 1, 16'd32768, 1'b0},
			'{WIN_GAUSS, 16'd4096, 16'd40000, 12'd1000, 0, 16'd0, 1'b0}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_reg(CFG_SPARE, 16'hFFFF);
		foreach (rows[r]) begin
			if (rows[r].wtype != cur_type || rows[r].len[12:0] != cur_len
			    || rows[r].hw != cur_hw)
				set_window(rows[r].wtype, rows[r].len, rows[r].hw);
			typed.weight = rows[r].weight;
			typed.oor = rows[r].oor;
			send_request(rows[r].idx, rows[r].known, typed);
		end

		count = 0;
		while (count < 1100) begin
			case ($urandom_range(0, 5))
				0: len = $urandom_range(2, 16);
				1: len = $urandom_range(0, 65535);
				2: len = 4096;
				default: len = $urandom_range(2, 512);
			endcase
			case ($urandom_range(0, 4))
				0: hw = 65535;
				1: hw = $urandom_range(0, 3);
				default: hw = $urandom_range(0, 65535);
			endcase
			wt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			set_window(wt, len, hw);
			gaps_on = $urandom_range(0, 3) != 0;
			neff = (cur_len > MAX_LENGTH) ? MAX_LENGTH : cur_len;
			repeat ($urandom_range(60, 160)) begin
				if (neff == 0 || $urandom_range(0, 9) == 0)
					send_request(12'($urandom_range(0, 4095)), 0, typed);
				else
					send_request(12'($urandom_range(0, neff - 1)), 0, typed);
				count++;
			end
		end

		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
sv/swg_pkg.sv
sv/swg_front.sv
sv/swg_queue.sv
sv/swg_cos.sv
sv/swg_gauss.sv
sv/spectral_window_generator_unit.sv
tb/sv/spectral_window_generator_unit_test.sv
